/* rtl/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types, codes and index helpers for the circular deque.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

    localparam int DEPTH    = 8;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [DATA_W-1:0]   t_word;

    localparam t_op OP_PUSH_FRONT = 3'd0;
    localparam t_op OP_PUSH_BACK  = 3'd1;
    localparam t_op OP_POP_FRONT  = 3'd2;
    localparam t_op OP_POP_BACK   = 3'd3;
    localparam t_op OP_LIST       = 3'd4;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    localparam t_idx IDX_LAST = t_idx'(DEPTH - 1);
    localparam t_idx IDX_ZERO = t_idx'(0);

    function automatic t_idx next_idx(input t_idx i);
        return (i == IDX_LAST) ? IDX_ZERO : t_idx'(i + t_idx'(1));
    endfunction

    function automatic t_idx prev_idx(input t_idx i);
        return (i == IDX_ZERO) ? IDX_LAST : t_idx'(i - t_idx'(1));
    endfunction

endpackage

`default_nettype wire

/* rtl/cdq_req_if.sv */
// ----------------------------------------------------------------------------
// cdq_req_if
// Request channel: one deque operation per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdq_req_if;
    logic               valid;
    logic               ready;
    cdq_pkg::t_op       op;
    logic signed [31:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

/* rtl/cdq_rsp_if.sv */
// ----------------------------------------------------------------------------
// cdq_rsp_if
// Result channel: status, data and a last marker per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdq_rsp_if;
    logic               valid;
    logic               ready;
    cdq_pkg::t_status   status;
    logic signed [31:0] data;
    logic               last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

`default_nettype wire

/* rtl/circular_deque.sv */
// ----------------------------------------------------------------------------
// circular_deque
// Push/pop at both ends of a circular store, plus a front-to-back listing.
// Push: IDLE, EXEC, then the result register. Pop: EXEC issues one RAM read,
// POPRD takes the read data into the result register. List: the same RAM read
// for the first entry, then one entry per cycle while the receiver takes results.
// One request is in flight at a time: the next one is taken once the FSM is back
// in IDLE. The result register lets it in while the last result still waits.
// Reset empties the deque; RAM content is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cdq_req_if.sink    i_req,
    cdq_rsp_if.source  o_rsp
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_POPRD  = 2'd2;
    localparam logic [1:0] S_LISTRD = 2'd3;

    logic [1:0]        r_state, n_state;
    cdq_pkg::t_idx     r_head, n_head;
    cdq_pkg::t_idx     r_tail, n_tail;
    logic              r_empty, n_empty;
    cdq_pkg::t_idx     r_ptr, n_ptr;
    cdq_pkg::t_op      r_op, n_op;
    cdq_pkg::t_word    r_value, n_value;

    logic              r_out_valid, n_out_valid;
    cdq_pkg::t_status  r_out_status, n_out_status;
    cdq_pkg::t_word    r_out_data, n_out_data;
    logic              r_out_last, n_out_last;

    logic              w_slot_free;
    logic              w_full;
    logic              w_load;
    logic              w_wr_en;
    cdq_pkg::t_idx     w_wr_addr;
    logic              w_rd_en;
    cdq_pkg::t_idx     w_rd_addr;
    cdq_pkg::t_word    w_rd_data;

    assign w_slot_free = !r_out_valid || o_rsp.ready;
    assign w_full      = !r_empty && (cdq_pkg::next_idx(r_tail) == r_head);

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.data   = $signed(r_out_data);
    assign o_rsp.last   = r_out_last;

    cdq_ram #(
        .WIDTH (cdq_pkg::DATA_W),
        .DEPTH (cdq_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_empty      = r_empty;
        n_ptr        = r_ptr;
        n_op         = r_op;
        n_value      = r_value;
        w_load       = 1'b0;
        n_out_status = cdq_pkg::ST_OK;
        n_out_data   = '0;
        n_out_last   = 1'b1;
        w_wr_en      = 1'b0;
        w_wr_addr    = cdq_pkg::IDX_ZERO;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.op;
                    n_value = cdq_pkg::t_word'(i_req.value);
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                    case (r_op) inside
                        cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_BACK: begin
                            w_load = 1'b1;
                            if (w_full) begin
                                n_out_status = cdq_pkg::ST_FULL;
                            end else begin
                                w_wr_en = 1'b1;
                                if (r_empty) begin
                                    n_head    = cdq_pkg::IDX_ZERO;
                                    n_tail    = cdq_pkg::IDX_ZERO;
                                    n_empty   = 1'b0;
                                    w_wr_addr = cdq_pkg::IDX_ZERO;
                                end else if (r_op == cdq_pkg::OP_PUSH_FRONT) begin
                                    n_head    = cdq_pkg::prev_idx(r_head);
                                    w_wr_addr = cdq_pkg::prev_idx(r_head);
                                end else begin
                                    n_tail    = cdq_pkg::next_idx(r_tail);
                                    w_wr_addr = cdq_pkg::next_idx(r_tail);
                                end
                            end
                        end
                        cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_BACK: begin
                            if (r_empty) begin
                                w_load       = 1'b1;
                                n_out_status = cdq_pkg::ST_EMPTY;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = (r_op == cdq_pkg::OP_POP_FRONT) ? r_head : r_tail;
                                n_state   = S_POPRD;
                            end
                        end
                        cdq_pkg::OP_LIST: begin
                            if (r_empty) begin
                                w_load       = 1'b1;
                                n_out_status = cdq_pkg::ST_EMPTY;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = r_head;
                                n_ptr     = r_head;
                                n_state   = S_LISTRD;
                            end
                        end
                        default: begin
                            // drop undefined operations without a result
                        end
                    endcase
                end
            end
            S_POPRD: begin
                if (w_slot_free) begin
                    w_load     = 1'b1;
                    n_out_data = w_rd_data;
                    n_state    = S_IDLE;
                    if (r_head == r_tail) begin
                        n_empty = 1'b1;
                        n_head  = cdq_pkg::IDX_ZERO;
                        n_tail  = cdq_pkg::IDX_ZERO;
                    end else if (r_op == cdq_pkg::OP_POP_FRONT) begin
                        n_head = cdq_pkg::next_idx(r_head);
                    end else begin
                        n_tail = cdq_pkg::prev_idx(r_tail);
                    end
                end
            end
            S_LISTRD: begin
                if (w_slot_free) begin
                    w_load     = 1'b1;
                    n_out_data = w_rd_data;
                    n_out_last = (r_ptr == r_tail);
                    if (r_ptr == r_tail) begin
                        n_state = S_IDLE;
                    end else begin
                        // advance and fetch the next entry for the following cycle
                        n_ptr     = cdq_pkg::next_idx(r_ptr);
                        w_rd_en   = 1'b1;
                        w_rd_addr = cdq_pkg::next_idx(r_ptr);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= cdq_pkg::IDX_ZERO;
            r_tail      <= cdq_pkg::IDX_ZERO;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_empty     <= n_empty;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_op    <= n_op;
        r_value <= n_value;
        if (w_load) begin
            r_out_status <= n_out_status;
            r_out_data   <= n_out_data;
            r_out_last   <= n_out_last;
        end
    end

endmodule

`default_nettype wire

/* rtl/cdq_ram.sv */
// ----------------------------------------------------------------------------
// cdq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]        i_wr_addr,
    input  wire logic [WIDTH-1:0]                i_wr_data,
    input  wire logic                            i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]        i_rd_addr,
    output logic      [WIDTH-1:0]                o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/cdq_checker.sv */
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks for the circular deque, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_checker (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_req_valid,
    input wire logic                    i_req_ready,
    input wire logic                    i_rsp_valid,
    input wire logic                    i_rsp_ready,
    input wire cdq_pkg::t_status        i_rsp_status,
    input wire logic signed [31:0]      i_rsp_data,
    input wire logic                    i_rsp_last
);

    // a stalled result holds its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_data) && $stable(i_rsp_last))
        else $error("result changed while stalled");

    // a refused request gives one result, marked last, with zero data
    a_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != cdq_pkg::ST_OK) |-> i_rsp_last && (i_rsp_data == 0))
        else $error("refusal with data or without last");

    // one request in flight: no transfer in the cycle after a transfer
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken back to back");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_rsp_valid)
        else $error("result valid after reset");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_data   (o_rsp.data),
    .i_rsp_last   (o_rsp.last)
);

`default_nettype wire

/* tb/sv/circular_deque_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_tb
// Drives push, pop, list and unused-code requests into the deque and checks every result
// against a deque model kept alongside it. Sender and receiver idle at random.
// The receiver also holds off once for a long stretch so the input stalls.
// ----------------------------------------------------------------------------

module circular_deque_tb;

    localparam int  NUM_ITEMS    = 200;
    localparam int  MAX_REPORTS  = 10;
    localparam int  IDLE_LIMIT   = 5000;
    localparam int  HOLD_AT      = 30;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  DRAIN_CYCLES = 20;
    localparam cdq_pkg::t_op OP_FIRST_UNUSED = 3'd5;
    localparam cdq_pkg::t_op OP_LAST_UNUSED  = 3'd7;

    typedef struct {
        cdq_pkg::t_op       op;
        logic signed [31:0] value;
    } t_request;

    typedef struct {
        cdq_pkg::t_status   status;
        logic signed [31:0] data;
        logic               last;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    cdq_req_if req_if ();
    cdq_rsp_if rsp_if ();

    circular_deque uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // deque model state
    logic signed [31:0] dq_mem [cdq_pkg::DEPTH];
    cdq_pkg::t_idx      dq_head = cdq_pkg::IDX_ZERO;
    cdq_pkg::t_idx      dq_tail = cdq_pkg::IDX_ZERO;
    bit                 dq_empty = 1'b1;

    t_request ops_to_send [$];
    t_result  results_due [$];
    t_request cur_req;
    t_result  want;

    int  ops_queued     = 0;
    int  counted_ops    = 0;
    int  ops_accepted   = 0;
    int  results_seen   = 0;
    int  errors         = 0;
    int  full_refusals  = 0;
    int  empty_refusals = 0;
    int  longest_list   = 0;
    int  unused_ops     = 0;

    bit  req_taken  = 1'b0;
    bit  rsp_taken  = 1'b0;
    bit  offering   = 1'b0;
    bit  accepting  = 1'b0;
    int  send_wait  = 0;
    int  send_run   = 0;
    int  take_wait  = 0;
    int  take_run   = 0;
    int  hold_left  = 0;
    int  idle_count = 0;

    function automatic cdq_pkg::t_idx wrap_up(input cdq_pkg::t_idx i);
        return cdq_pkg::t_idx'((int'(i) + 1) % cdq_pkg::DEPTH);
    endfunction

    function automatic cdq_pkg::t_idx wrap_down(input cdq_pkg::t_idx i);
        return cdq_pkg::t_idx'((int'(i) + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH);
    endfunction

    function automatic void owe(input cdq_pkg::t_status status,
                                input logic signed [31:0] data, input logic last);
        t_result r;
        r.status = status;
        r.data   = data;
        r.last   = last;
        results_due.push_back(r);
    endfunction

    // Apply one request to the model deque and queue the results it owes.
    function automatic void deque_apply(input cdq_pkg::t_op op,
                                        input logic signed [31:0] val);
        cdq_pkg::t_idx k;
        int            n;
        case (op)
            cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_BACK: begin
                if (!dq_empty && wrap_up(dq_tail) == dq_head) begin
                    full_refusals++;
                    owe(cdq_pkg::ST_FULL, '0, 1'b1);
                end else begin
                    if (dq_empty) begin
                        dq_head   = cdq_pkg::IDX_ZERO;
                        dq_tail   = cdq_pkg::IDX_ZERO;
                        dq_empty  = 1'b0;
                        dq_mem[0] = val;
                    end else if (op == cdq_pkg::OP_PUSH_FRONT) begin
                        dq_head         = wrap_down(dq_head);
                        dq_mem[dq_head] = val;
                    end else begin
                        dq_tail         = wrap_up(dq_tail);
                        dq_mem[dq_tail] = val;
                    end
                    owe(cdq_pkg::ST_OK, '0, 1'b1);
                end
            end
            cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_BACK: begin
                if (dq_empty) begin
                    empty_refusals++;
                    owe(cdq_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    owe(cdq_pkg::ST_OK,
                        (op == cdq_pkg::OP_POP_FRONT) ? dq_mem[dq_head] : dq_mem[dq_tail],
                        1'b1);
                    if (dq_head == dq_tail) begin
                        dq_empty = 1'b1;
                        dq_head  = cdq_pkg::IDX_ZERO;
                        dq_tail  = cdq_pkg::IDX_ZERO;
                    end else if (op == cdq_pkg::OP_POP_FRONT) begin
                        dq_head = wrap_up(dq_head);
                    end else begin
                        dq_tail = wrap_down(dq_tail);
                    end
                end
            end
            cdq_pkg::OP_LIST: begin
                if (dq_empty) begin
                    empty_refusals++;
                    owe(cdq_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    k = dq_head;
                    for (n = 0; n < cdq_pkg::DEPTH; n++) begin
                        owe(cdq_pkg::ST_OK, dq_mem[k], k == dq_tail);
                        if (k == dq_tail) break;
                        k = wrap_up(k);
                    end
                    if (n + 1 > longest_list) longest_list = n + 1;
                end
            end
            default: unused_ops++;
        endcase
    endfunction

    function automatic void queue_op(input cdq_pkg::t_op op, input logic signed [31:0] val);
        t_request r;
        r.op    = op;
        r.value = val;
        ops_to_send.push_back(r);
        ops_queued++;
        if (op < OP_FIRST_UNUSED) counted_ops++;
    endfunction

    // Idle cycles before the next transfer; now and then a run with no idling.
    function automatic int draw_wait(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            run = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (offering && req_taken) begin
                offering  = 1'b0;
                send_wait = draw_wait(send_run);
            end
            if (!offering && ops_to_send.size() != 0) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else begin
                    cur_req  = ops_to_send.pop_front();
                    offering = 1'b1;
                end
            end
            req_if.valid <= offering;
            req_if.op    <= cur_req.op;
            req_if.value <= cur_req.value;
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_taken) begin
                accepting = 1'b0;
                take_wait = draw_wait(take_run);
                // hold off long enough for the block to back up into the sender
                if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (!accepting) begin
                if (take_wait > 0) take_wait--;
                else accepting = 1'b1;
            end
            rsp_if.ready <= accepting;
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
            rsp_taken <= 1'b0;
        end else begin
            req_taken <= req_if.valid && req_if.ready;
            rsp_taken <= rsp_if.valid && rsp_if.ready;
            if (rsp_if.valid && rsp_if.ready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("result %0d: unexpected, status %0d data %0d last %0d",
                                 results_seen, rsp_if.status, rsp_if.data, rsp_if.last);
                end else begin
                    want = results_due.pop_front();
                    if (rsp_if.status !== want.status || rsp_if.data !== want.data ||
                        rsp_if.last !== want.last) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display("result %0d: expected status %0d data %0d last %0d",
                                     results_seen, want.status, want.data, want.last);
                            $display("    got status %0d data %0d last %0d",
                                     rsp_if.status, rsp_if.data, rsp_if.last);
                        end
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                ops_accepted++;
                deque_apply(req_if.op, req_if.value);
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_count <= 0;
        end else if (idle_count >= IDLE_LIMIT) begin
            $display("Timeout after %0d cycles without a transfer", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        int                 roll;
        int                 push_cut;
        cdq_pkg::t_op       op;
        logic signed [31:0] val;

        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.op    = cdq_pkg::OP_PUSH_FRONT;
        req_if.value = '0;
        rsp_if.ready = 1'b0;
        cur_req.op    = cdq_pkg::OP_PUSH_FRONT;
        cur_req.value = '0;

        // directed: refusals on empty, single-entry push/pop, fill, refusals on full, unused codes
        queue_op(cdq_pkg::OP_POP_FRONT, 32'sd5);
        queue_op(cdq_pkg::OP_POP_BACK, -32'sd5);
        queue_op(cdq_pkg::OP_LIST, '0);
        queue_op(cdq_pkg::OP_PUSH_BACK, 32'sh7FFF_FFFF);
        queue_op(cdq_pkg::OP_POP_BACK, '0);
        queue_op(cdq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
        queue_op(cdq_pkg::OP_PUSH_BACK, -32'sd1);
        queue_op(cdq_pkg::OP_LIST, '0);
        queue_op(cdq_pkg::OP_PUSH_FRONT, 32'sd0);
        queue_op(cdq_pkg::OP_PUSH_BACK, 32'sh5555_5555);
        queue_op(cdq_pkg::OP_PUSH_FRONT, 32'shAAAA_AAAA);
        queue_op(cdq_pkg::OP_PUSH_BACK, 32'sd1);
        queue_op(cdq_pkg::OP_PUSH_FRONT, -32'sd2);
        queue_op(cdq_pkg::OP_PUSH_FRONT, 32'sh1234_5678);
        queue_op(cdq_pkg::OP_PUSH_FRONT, 32'sd99);
        queue_op(cdq_pkg::OP_PUSH_BACK, 32'sd98);
        queue_op(cdq_pkg::OP_LIST, '0);
        queue_op(OP_FIRST_UNUSED, 32'sh7FFF_FFFF);
        queue_op(OP_LAST_UNUSED, 32'sh8000_0000);
        queue_op(cdq_pkg::OP_POP_FRONT, '0);
        queue_op(cdq_pkg::OP_POP_BACK, '0);
        queue_op(cdq_pkg::OP_LIST, '0);

        // random: alternate push-heavy, pop-heavy and balanced stretches
        while (ops_queued < NUM_ITEMS) begin
            roll     = $urandom_range(0, 99);
            push_cut = ((counted_ops / 25) % 3 == 0) ? 75 :
                       ((counted_ops / 25) % 3 == 1) ? 35 : 56;
            if (roll < 3)
                op = cdq_pkg::t_op'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
            else if (roll < 13)
                op = cdq_pkg::OP_LIST;
            else if (roll < push_cut)
                op = $urandom_range(0, 1) ? cdq_pkg::OP_PUSH_BACK : cdq_pkg::OP_PUSH_FRONT;
            else
                op = $urandom_range(0, 1) ? cdq_pkg::OP_POP_BACK : cdq_pkg::OP_POP_FRONT;
            case ($urandom_range(0, 15))
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7FFF_FFFF;
                2:       val = '0;
                3:       val = -32'sd1;
                default: val = $urandom;
            endcase
            queue_op(op, val);
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_accepted < ops_queued || results_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (results_due.size() != 0) begin
            errors += results_due.size();
            $display("%0d results never arrived", results_due.size());
        end

        $display("Sent %0d requests (%0d with unused codes) and checked %0d results.",
                 ops_accepted, unused_ops, results_seen);
        $display("Refused %0d pushes on full and %0d requests on empty; longest listing %0d.",
                 full_refusals, empty_refusals, longest_list);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
